// ===== rtl/rdwre_pkg.sv =====
// shared constants, types and state codes of the row delta word encoder
package rdwre_pkg;

  localparam int MAX_ROW_WORDS = 64;
  localparam int RUN_LIMIT     = 127;
  localparam int POS_W         = $clog2(MAX_ROW_WORDS);
  localparam int CNT_W         = 7;
  localparam int WORD_W        = 16;
  localparam int HDR_W         = 8;
  localparam int CFG_W         = 7;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_W-1:0] ROW_WORDS_RESET = 7'd50;
  localparam logic [HDR_W-1:0] REPEAT_BASE     = 8'd128;
  localparam logic [0:0]       REG_ROW_WORDS   = 1'b0;

  typedef struct packed {
    logic [WORD_W-1:0] delta;
    logic              eq_prev;
    logic              row_end;
  } word_entry_t;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_START,
    ST_EXTEND,
    ST_EMIT
  } back_state_t;

endpackage

// ===== rtl/row_delta_word_rle_encoder_core.sv =====
// top level: row delta word encoder with config register, front, queue and back end
//
//   channel   signals                                         direction
//   pixel     pixel_valid/ready, pixel_word, first_row        in
//   packet    packet_valid/ready, has_header, header,         out
//             data_word, row_done
//   config    psel, penable, pwrite, paddr, pwdata, prdata    apb, row_words at 0x0
//
// the front takes a word only when its previous-row read is fresh; the bubble after each
// word is the previous-row memory read that follows the word position.
// at row end the back end scans each run one word a cycle and then streams its packet
// words one a cycle while packet_ready holds; the four-word queue lets the front take up
// to four words of the next row meanwhile, then the front stalls.
// reset clears the previous-row valid bits at once, no clearing pass.
module row_delta_word_rle_encoder_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         pixel_valid,
  output logic                         pixel_ready,
  input  logic [rdwre_pkg::WORD_W-1:0] pixel_word,
  input  logic                         first_row,
  output logic                         packet_valid,
  input  logic                         packet_ready,
  output logic                         has_header,
  output logic [rdwre_pkg::HDR_W-1:0]  header,
  output logic [rdwre_pkg::WORD_W-1:0] data_word,
  output logic                         row_done
);

  logic [rdwre_pkg::CFG_W-1:0] row_words;
  logic                        push;
  logic                        push_ready;
  rdwre_pkg::word_entry_t      push_entry;
  logic                        pop_valid;
  logic                        pop;
  rdwre_pkg::word_entry_t      pop_entry;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == rdwre_pkg::REG_ROW_WORDS) ? 32'(row_words) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_words <= rdwre_pkg::ROW_WORDS_RESET;
    end else if (psel && penable && pwrite && paddr[2] == rdwre_pkg::REG_ROW_WORDS) begin
      row_words <= pwdata[rdwre_pkg::CFG_W-1:0];
    end
  end

  rdwre_front u_front (
    .clk         (clk),
    .rst         (rst),
    .row_words   (row_words),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel_word  (pixel_word),
    .first_row   (first_row),
    .push        (push),
    .push_ready  (push_ready),
    .push_entry  (push_entry)
  );

  rdwre_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_entry  (pop_entry)
  );

  rdwre_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop          (pop),
    .pop_entry    (pop_entry),
    .packet_valid (packet_valid),
    .packet_ready (packet_ready),
    .has_header   (has_header),
    .header       (header),
    .data_word    (data_word),
    .row_done     (row_done)
  );

`ifndef SYNTH
  // the previous-row read leaves a bubble after every word taken
  assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_ready |=> !pixel_ready)
    else $error("pixel word taken on two cycles in a row");

  assert property (@(posedge clk)
    rst |=> row_words == rdwre_pkg::ROW_WORDS_RESET)
    else $error("row_words not at reset value after reset");

  assert property (@(posedge clk) disable iff (rst)
    packet_valid && has_header |-> header != '0 && header != rdwre_pkg::REPEAT_BASE)
    else $error("packet header with zero count");

  assert property (@(posedge clk) disable iff (rst)
    packet_valid && !has_header |-> header == '0)
    else $error("header set on a word that does not open a packet");
`endif

endmodule

// ===== rtl/rdwre_front.sv =====
// front: takes pixel words, forms the row delta and tags row end and equal neighbors
module rdwre_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [rdwre_pkg::CFG_W-1:0]            row_words,
  input  logic                                   pixel_valid,
  output logic                                   pixel_ready,
  input  logic [rdwre_pkg::WORD_W-1:0]           pixel_word,
  input  logic                                   first_row,
  output logic                                   push,
  input  logic                                   push_ready,
  output rdwre_pkg::word_entry_t                 push_entry
);

  logic [rdwre_pkg::POS_W-1:0]     pos;
  logic [rdwre_pkg::WORD_W-1:0]    prev_mem [rdwre_pkg::MAX_ROW_WORDS];
  logic [rdwre_pkg::MAX_ROW_WORDS-1:0] prev_valid;
  logic [rdwre_pkg::WORD_W-1:0]    prev_rd;
  logic [rdwre_pkg::WORD_W-1:0]    last_delta;
  logic [rdwre_pkg::WORD_W-1:0]    prev_word;
  logic [rdwre_pkg::WORD_W-1:0]    delta;
  logic                            prev_fresh;
  logic                            accept;
  logic                            row_end;
  logic [rdwre_pkg::CFG_W-1:0]     row_len;
  logic [rdwre_pkg::CFG_W-1:0]     pos_plus;

  always_comb begin
    row_len = row_words;
    if (row_words == '0) begin
      row_len = rdwre_pkg::CFG_W'(1);
    end else if (row_words > rdwre_pkg::CFG_W'(rdwre_pkg::MAX_ROW_WORDS)) begin
      row_len = rdwre_pkg::CFG_W'(rdwre_pkg::MAX_ROW_WORDS);
    end
  end

  assign pos_plus  = rdwre_pkg::CFG_W'(pos) + rdwre_pkg::CFG_W'(1);
  assign row_end   = (pos_plus >= row_len);
  // unwritten previous-row entries read as zero
  assign prev_word = (first_row || !prev_valid[pos]) ? '0 : prev_rd;
  assign delta     = pixel_word ^ prev_word;

  // prev_rd is registered from the position, so it is stale right after each word
  assign pixel_ready = prev_fresh && push_ready;
  assign accept      = pixel_valid && pixel_ready;
  assign push        = accept;

  assign push_entry.delta   = delta;
  assign push_entry.eq_prev = (pos != '0) && (delta == last_delta);
  assign push_entry.row_end = row_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      prev_valid <= '0;
      prev_fresh <= 1'b0;
    end else begin
      prev_fresh <= !accept;
      if (accept) begin
        prev_valid[pos] <= 1'b1;
        pos             <= row_end ? '0 : pos_plus[rdwre_pkg::POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    prev_rd <= prev_mem[pos];
    if (accept) begin
      prev_mem[pos] <= pixel_word;
      last_delta    <= delta;
    end
  end

endmodule

// ===== rtl/rdwre_queue.sv =====
// short word queue between the front and the packet back end
module rdwre_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   push_ready,
  input  rdwre_pkg::word_entry_t push_entry,
  output logic                   pop_valid,
  input  logic                   pop,
  output rdwre_pkg::word_entry_t pop_entry
);

  rdwre_pkg::word_entry_t            entries [rdwre_pkg::QUEUE_DEPTH];
  logic [rdwre_pkg::QPTR_W-1:0]      wr_ptr;
  logic [rdwre_pkg::QPTR_W-1:0]      rd_ptr;
  logic [rdwre_pkg::QPTR_W:0]        count;
  logic                              do_push;
  logic                              do_pop;

  assign push_ready = (count != (rdwre_pkg::QPTR_W+1)'(rdwre_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

// ===== rtl/rdwre_back.sv =====
// back end: buffers a delta row, scans it into runs and emits packet words
module rdwre_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pop_valid,
  output logic                         pop,
  input  rdwre_pkg::word_entry_t       pop_entry,
  output logic                         packet_valid,
  input  logic                         packet_ready,
  output logic                         has_header,
  output logic [rdwre_pkg::HDR_W-1:0]  header,
  output logic [rdwre_pkg::WORD_W-1:0] data_word,
  output logic                         row_done
);

  rdwre_pkg::back_state_t               state;
  rdwre_pkg::back_state_t               state_next;
  logic [rdwre_pkg::WORD_W-1:0]         delta_mem [rdwre_pkg::MAX_ROW_WORDS];
  logic [rdwre_pkg::MAX_ROW_WORDS-1:0]  eq_flags;
  logic [rdwre_pkg::POS_W-1:0]          wr_idx;
  logic [rdwre_pkg::POS_W-1:0]          last;
  logic [rdwre_pkg::POS_W-1:0]          start;
  logic [rdwre_pkg::POS_W-1:0]          rd_addr;
  logic [rdwre_pkg::CNT_W-1:0]          len;
  logic [rdwre_pkg::CNT_W-1:0]          len_inc;
  logic [rdwre_pkg::CNT_W-1:0]          emit_cnt;
  logic [rdwre_pkg::CNT_W-1:0]          run_end;
  logic [rdwre_pkg::CNT_W-1:0]          words;
  logic                                 rep;
  logic                                 do_pop;
  logic                                 scan_past;
  logic                                 scan_match;
  logic                                 cap_hit;
  logic                                 issue_last;
  logic                                 row_fin;
  logic                                 rd_issue;
  logic                                 rd_take;
  logic                                 rd_valid;
  logic                                 rd_hdr;
  logic [rdwre_pkg::HDR_W-1:0]          rd_header;
  logic                                 rd_done;
  logic [rdwre_pkg::WORD_W-1:0]         rd_data;

  // next word past the current run, also where the next run starts
  assign run_end    = rdwre_pkg::CNT_W'(start) + len;
  assign scan_past  = (run_end > rdwre_pkg::CNT_W'(last));
  assign row_fin    = scan_past;
  assign scan_match = (eq_flags[run_end[rdwre_pkg::POS_W-1:0]] == rep);
  assign len_inc    = len + rdwre_pkg::CNT_W'(1);
  assign cap_hit    = (len_inc >= rdwre_pkg::CNT_W'(rdwre_pkg::RUN_LIMIT));
  assign words      = rep ? rdwre_pkg::CNT_W'(1) : len;
  assign issue_last = ((emit_cnt + rdwre_pkg::CNT_W'(1)) == words);
  assign rd_addr    = start + emit_cnt[rdwre_pkg::POS_W-1:0];
  assign rd_take    = rd_valid && (!packet_valid || packet_ready);
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdwre_pkg::ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    rd_issue   = 1'b0;
    case (state)
      rdwre_pkg::ST_COLLECT: begin
        pop = 1'b1;
        if (pop_valid && pop_entry.row_end) begin
          state_next = rdwre_pkg::ST_START;
        end
      end
      rdwre_pkg::ST_START: begin
        state_next = (start == last) ? rdwre_pkg::ST_EMIT : rdwre_pkg::ST_EXTEND;
      end
      rdwre_pkg::ST_EXTEND: begin
        if (scan_past || !scan_match || cap_hit) begin
          state_next = rdwre_pkg::ST_EMIT;
        end
      end
      rdwre_pkg::ST_EMIT: begin
        rd_issue = !rd_valid || rd_take;
        if (rd_issue && issue_last) begin
          state_next = row_fin ? rdwre_pkg::ST_COLLECT : rdwre_pkg::ST_START;
        end
      end
      default: begin
        state_next = rdwre_pkg::ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx       <= '0;
      start        <= '0;
      emit_cnt     <= '0;
      rd_valid     <= 1'b0;
      packet_valid <= 1'b0;
    end else begin
      if (do_pop) begin
        wr_idx <= pop_entry.row_end ? '0 : wr_idx + 1'b1;
        if (pop_entry.row_end) begin
          start <= '0;
        end
      end
      if (rd_issue) begin
        if (issue_last) begin
          emit_cnt <= '0;
          start    <= run_end[rdwre_pkg::POS_W-1:0];
        end else begin
          emit_cnt <= emit_cnt + 1'b1;
        end
      end
      if (rd_issue) begin
        rd_valid <= 1'b1;
      end else if (rd_take) begin
        rd_valid <= 1'b0;
      end
      if (rd_take) begin
        packet_valid <= 1'b1;
      end else if (packet_ready) begin
        packet_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      delta_mem[wr_idx] <= pop_entry.delta;
    end
    if (rd_issue) begin
      rd_data <= delta_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      eq_flags[wr_idx] <= pop_entry.eq_prev;
      if (pop_entry.row_end) begin
        last <= wr_idx;
      end
    end
    // a run opens on two words, or one when it is the last word of the row
    if (state == rdwre_pkg::ST_START) begin
      if (start == last) begin
        rep <= 1'b0;
        len <= rdwre_pkg::CNT_W'(1);
      end else begin
        rep <= eq_flags[start + rdwre_pkg::POS_W'(1)];
        len <= rdwre_pkg::CNT_W'(2);
      end
    end
    if (state == rdwre_pkg::ST_EXTEND && !scan_past) begin
      if (scan_match) begin
        len <= len_inc;
      end else if (!rep) begin
        // the word before an equal pair opens the next repeat
        len <= len - rdwre_pkg::CNT_W'(1);
      end
    end
    if (rd_issue) begin
      rd_hdr  <= (emit_cnt == '0);
      rd_done <= issue_last && row_fin;
      if (emit_cnt != '0) begin
        rd_header <= '0;
      end else if (rep) begin
        rd_header <= rdwre_pkg::REPEAT_BASE + rdwre_pkg::HDR_W'(len);
      end else begin
        rd_header <= rdwre_pkg::HDR_W'(len);
      end
    end
    if (rd_take) begin
      has_header <= rd_hdr;
      header     <= rd_header;
      data_word  <= rd_data;
      row_done   <= rd_done;
    end
  end

endmodule

// ===== verif/row_delta_word_rle_encoder_core_tb.sv =====
// testbench for the row delta word encoder: queued pixel driver, packet monitor, row predictor
module row_delta_word_rle_encoder_core_tb;

  localparam logic [2:0] ADDR_ROW_WORDS = {rdwre_pkg::REG_ROW_WORDS, 2'b00};
  localparam logic [2:0] ADDR_UNUSED    = 3'd4;
  localparam int SETTLE_CYCLES = 4 * rdwre_pkg::MAX_ROW_WORDS + 20;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic [rdwre_pkg::WORD_W-1:0] word;
    logic                         first;
  } pixel_item_t;

  typedef struct packed {
    logic                         has_hdr;
    logic [rdwre_pkg::HDR_W-1:0]  hdr;
    logic [rdwre_pkg::WORD_W-1:0] dword;
    logic                         rend;
  } packet_word_t;

  typedef enum int {ROW_NOISE, ROW_FLAT, ROW_LITERAL, ROW_RUNS} row_style_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [2:0]                   paddr = '0;
  logic [31:0]                  pwdata = '0;
  logic [31:0]                  prdata;
  logic                         pready;
  logic                         pixel_valid = 1'b0;
  logic                         pixel_ready;
  logic [rdwre_pkg::WORD_W-1:0] pixel_word = '0;
  logic                         first_row = 1'b0;
  logic                         packet_valid;
  logic                         packet_ready = 1'b0;
  logic                         has_header;
  logic [rdwre_pkg::HDR_W-1:0]  header;
  logic [rdwre_pkg::WORD_W-1:0] data_word;
  logic                         row_done;

  row_delta_word_rle_encoder_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel_word   (pixel_word),
    .first_row    (first_row),
    .packet_valid (packet_valid),
    .packet_ready (packet_ready),
    .has_header   (has_header),
    .header       (header),
    .data_word    (data_word),
    .row_done     (row_done)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // stimulus and scoreboard state
  pixel_item_t  pixel_queue[$];
  packet_word_t pending_packets[$];
  packet_word_t row_packets[$];
  int           queued_cnt = 0;
  int           accepted_cnt = 0;
  int           mismatches = 0;
  int           cycle_cnt = 0;
  int           send_idle = 15;
  int           recv_stall = 88;
  bit           pix_fire = 1'b0;
  bit [rdwre_pkg::WORD_W-1:0] gen_prev[rdwre_pkg::MAX_ROW_WORDS];

  // predictor state
  bit [rdwre_pkg::WORD_W-1:0] prev_row_mem[rdwre_pkg::MAX_ROW_WORDS];
  bit [rdwre_pkg::WORD_W-1:0] delta_mem[rdwre_pkg::MAX_ROW_WORDS];
  int                         word_pos = 0;
  bit [rdwre_pkg::CFG_W-1:0]  row_words_cfg = rdwre_pkg::ROW_WORDS_RESET;

  function automatic bit [rdwre_pkg::WORD_W-1:0] delta_word_at(int i);
    if (i < 0 || i >= rdwre_pkg::MAX_ROW_WORDS) return '0;
    return delta_mem[i];
  endfunction

  function automatic void emit_packet_words(int start, int cnt, bit rep);
    if (cnt < 1) return;
    if (rep) begin
      row_packets.push_back({1'b1, rdwre_pkg::REPEAT_BASE + rdwre_pkg::HDR_W'(cnt),
                             delta_word_at(start), 1'b0});
      return;
    end
    for (int i = 0; i < cnt && row_packets.size() < rdwre_pkg::MAX_ROW_WORDS; i++) begin
      row_packets.push_back({i == 0, (i == 0) ? rdwre_pkg::HDR_W'(cnt) : rdwre_pkg::HDR_W'(0),
                             delta_word_at(start + i), 1'b0});
    end
  endfunction

  // run-length scan of the buffered delta row
  function automatic void pack_delta_row(int n);
    int last_i, p1, p2, cnt;
    bit rep;
    last_i = n - 1;
    p1 = 0;
    p2 = 0;
    cnt = 0;
    rep = 1'b0;
    row_packets.delete();
    do begin
      if (p1 >= p2) begin
        p2 = p1 + 1;
        cnt = 2;
        rep = (p2 <= last_i) ? (delta_word_at(p1) == delta_word_at(p2)) : 1'b0;
      end else if ((delta_word_at(p2) == delta_word_at(p2 + 1)) == rep) begin
        cnt++;
        if (cnt >= rdwre_pkg::RUN_LIMIT) begin
          emit_packet_words(p1, cnt, rep);
          p1 = p2 + 2;
        end else begin
          p2++;
        end
      end else if (rep) begin
        emit_packet_words(p1, cnt, 1'b1);
        p1 = p2 + 1;
        rep = 1'b0;
      end else begin
        cnt--;
        emit_packet_words(p1, cnt, 1'b0);
        p1 = p2;
        rep = 1'b1;
      end
    end while (p2 < last_i);
    if (p1 <= last_i) begin
      // lone word at row end goes out as a one-word literal
      if (p2 > last_i) begin
        cnt = 1;
        rep = 1'b0;
      end
      emit_packet_words(p1, cnt, rep);
    end
    if (row_packets.size() > 0) row_packets[row_packets.size() - 1].rend = 1'b1;
    foreach (row_packets[i]) pending_packets.push_back(row_packets[i]);
  endfunction

  function automatic void absorb_pixel_word(bit [rdwre_pkg::WORD_W-1:0] w, bit first);
    int n, pos;
    bit [rdwre_pkg::WORD_W-1:0] prev;
    n = int'(row_words_cfg);
    if (n < 1) n = 1;
    if (n > rdwre_pkg::MAX_ROW_WORDS) n = rdwre_pkg::MAX_ROW_WORDS;
    pos = word_pos;
    if (pos >= rdwre_pkg::MAX_ROW_WORDS) pos = rdwre_pkg::MAX_ROW_WORDS - 1;
    prev = first ? '0 : prev_row_mem[pos];
    delta_mem[pos] = w ^ prev;
    prev_row_mem[pos] = w;
    // a shortened row length can end the row early
    if (pos + 1 >= n) begin
      word_pos = 0;
      pack_delta_row(pos + 1);
    end else begin
      word_pos = pos + 1;
    end
  endfunction

  function automatic void check_packet_word();
    packet_word_t got, want;
    got = {has_header, header, data_word, row_done};
    if (pending_packets.size() == 0) begin
      $display("%0t: unexpected packet word, expected none", $time);
      $display("%0t:   actual hdr_v=%0b hdr=%0d word=%h done=%0b",
               $time, got.has_hdr, got.hdr, got.dword, got.rend);
      mismatches++;
    end else begin
      want = pending_packets.pop_front();
      if (got.has_hdr !== want.has_hdr || got.hdr !== want.hdr ||
          got.dword !== want.dword || got.rend !== want.rend) begin
        $display("%0t: packet word mismatch, expected hdr_v=%0b hdr=%0d word=%h done=%0b",
                 $time, want.has_hdr, want.hdr, want.dword, want.rend);
        $display("%0t:   actual hdr_v=%0b hdr=%0d word=%h done=%0b",
                 $time, got.has_hdr, got.hdr, got.dword, got.rend);
        mismatches++;
      end
    end
  endfunction

  // monitor: sample both handshakes at the rising edge
  always @(posedge clk) begin
    pix_fire = pixel_valid && pixel_ready;
    if (!rst) begin
      if (pix_fire) begin
        absorb_pixel_word(pixel_word, first_row);
        accepted_cnt++;
      end
      if (packet_valid && packet_ready) check_packet_word();
    end
  end

  // driver: next word goes out at the falling edge
  always @(negedge clk) begin : feed_pixels
    pixel_item_t nxt;
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (!pixel_valid || pix_fire) begin
      if (pixel_queue.size() > 0 && $urandom_range(99, 0) >= send_idle) begin
        nxt = pixel_queue.pop_front();
        pixel_valid <= 1'b1;
        pixel_word <= nxt.word;
        first_row <= nxt.first;
      end else begin
        pixel_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    packet_ready <= ($urandom_range(99, 0) >= recv_stall);
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_ROW_WORDS) row_words_cfg = val[rdwre_pkg::CFG_W-1:0];
  endtask

  task automatic queue_word(logic [rdwre_pkg::WORD_W-1:0] w, logic first);
    pixel_queue.push_back({w, first});
    queued_cnt++;
  endtask

  // wait until every word is taken and every packet word is back
  task automatic drain();
    do begin
      @(negedge clk);
    end while (accepted_cnt != queued_cnt || pending_packets.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic bit [rdwre_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(3, 0))
      0: return '0;
      1: return '1;
      default: return rdwre_pkg::WORD_W'($urandom);
    endcase
  endfunction

  // deltas are shaped, words are derived from the generator's copy of the last row
  task automatic queue_row(int n, row_style_t style, bit first);
    int left;
    bit lit, fr;
    bit [rdwre_pkg::WORD_W-1:0] run_val, d, last_d, w;
    left = 0;
    lit = 1'b0;
    run_val = pick_word();
    last_d = '0;
    for (int i = 0; i < n; i++) begin
      fr = first;
      case (style)
        ROW_NOISE: begin
          d = rdwre_pkg::WORD_W'($urandom);
          fr = 1'($urandom_range(1, 0));
        end
        ROW_FLAT: d = run_val;
        ROW_LITERAL: begin
          d = rdwre_pkg::WORD_W'($urandom);
          if (i > 0 && d == last_d) d = ~d;
        end
        default: begin
          if (left == 0) begin
            left = $urandom_range(6, 1);
            lit = 1'($urandom_range(1, 0));
            run_val = pick_word();
          end
          d = lit ? rdwre_pkg::WORD_W'($urandom) : run_val;
          left--;
        end
      endcase
      w = (style == ROW_NOISE || fr) ? d : d ^ gen_prev[i];
      gen_prev[i] = w;
      last_d = d;
      queue_word(w, fr);
    end
  endtask

  task automatic run_setting(int rw, int rows);
    int len, pick;
    row_style_t style;
    drain();
    reg_write(ADDR_ROW_WORDS, rw);
    len = (rw < 1) ? 1 : (rw > rdwre_pkg::MAX_ROW_WORDS) ? rdwre_pkg::MAX_ROW_WORDS : rw;
    for (int r = 0; r < rows; r++) begin
      pick = $urandom_range(9, 0);
      style = (pick == 0) ? ROW_NOISE : (pick == 1) ? ROW_FLAT :
              (pick == 2) ? ROW_LITERAL : ROW_RUNS;
      queue_row(len, style,
                (r == 0) ? 1'($urandom_range(1, 0)) : ($urandom_range(3, 0) == 0));
    end
  endtask

  initial begin
    foreach (prev_row_mem[i]) begin
      prev_row_mem[i] = '0;
      delta_mem[i] = '0;
      gen_prev[i] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // one-word rows, then a zero length that acts as one
    reg_write(ADDR_ROW_WORDS, 1);
    queue_word(16'hFFFF, 1'b1);
    queue_word(16'hFFFF, 1'b0);
    drain();
    reg_write(ADDR_ROW_WORDS, 0);
    queue_word(16'h0000, 1'b0);
    drain();

    // two-word repeat and literal; write to an address past the register list
    reg_write(ADDR_ROW_WORDS, 2);
    reg_write(ADDR_UNUSED, 9);
    queue_word(16'hA5A5, 1'b1); queue_word(16'hA5A5, 1'b1);
    queue_word(16'h0001, 1'b1); queue_word(16'h8000, 1'b1);
    drain();

    // repeat then literal, all-zero delta row, literal then repeat
    reg_write(ADDR_ROW_WORDS, 5);
    queue_word(16'd7, 1'b1); queue_word(16'd7, 1'b1); queue_word(16'd7, 1'b1);
    queue_word(16'd1, 1'b1); queue_word(16'd2, 1'b1);
    queue_word(16'd7, 1'b0); queue_word(16'd7, 1'b0); queue_word(16'd7, 1'b0);
    queue_word(16'd1, 1'b0); queue_word(16'd2, 1'b0);
    queue_word(16'd1, 1'b1); queue_word(16'd2, 1'b1); queue_word(16'd3, 1'b1);
    queue_word(16'd3, 1'b1); queue_word(16'd3, 1'b1);

    // row length cut below the position reached: row ends on the next word
    queue_word(16'd5, 1'b1); queue_word(16'd5, 1'b1);
    drain();
    reg_write(ADDR_ROW_WORDS, 1);
    queue_word(16'd9, 1'b1);

    run_setting(4, 5);
    run_setting(127, 1);

    drain();
    send_idle = 88;
    recv_stall = 15;
    repeat (3) run_setting($urandom_range(12, 1), 2);

    drain();
    send_idle = 0;
    recv_stall = 0;
    repeat (3) run_setting($urandom_range(12, 1), 2);

    drain();
    if (mismatches == 0 && pending_packets.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule
